>>> src/lim_pkg.sv
package lim_pkg;

	// Fixed point format: Q16.16, two's complement
	localparam int FRAC = 16;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic [30:0] DEPTH_RST = 31'h0001_0000;

	// Configuration register indexes
	localparam logic [1:0] CFG_PROJ  = 2'd0;
	localparam logic [1:0] CFG_FEAT  = 2'd1;
	localparam logic [1:0] CFG_DNZ   = 2'd2;
	localparam logic [1:0] CFG_DEPTH = 2'd3;

	// Projection modes; the unused code behaves as perspective
	localparam logic [1:0] MODE_PERSP  = 2'd0;
	localparam logic [1:0] MODE_PAR    = 2'd1;
	localparam logic [1:0] MODE_PARFOC = 2'd2;

	// Focus features; the sigma-variance feature uses variance_deriv, other codes use the gradient term
	localparam logic [1:0] FEAT_NONE = 2'd0;
	localparam logic [1:0] FEAT_VAR  = 2'd2;

	// Pipeline layout
	localparam int FRONT_STG = 4;
	localparam int MID_STG   = 3;
	localparam int DIV_STG   = 12;
	localparam int NUM_STG   = FRONT_STG + MID_STG + DIV_STG + 1;

	// Divider: 48-bit dividend, 31-bit divisor, 4 quotient bits per stage
	localparam int DIV_NW  = 48;
	localparam int DIV_RW  = 31;
	localparam int DIV_BPS = DIV_NW / DIV_STG;

	// Divider lanes
	localparam int NUM_LANE = 3;
	localparam int LANE_TX  = 0;
	localparam int LANE_TY  = 1;
	localparam int LANE_TZ  = 2;

	typedef struct packed {
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] smooth_grad_x;
		logic signed [31:0] smooth_grad_y;
		logic signed [31:0] variance_deriv;
		logic               is_noise;
		logic               last_pixel;
	} lim_in_t;

	typedef struct packed {
		logic signed [31:0] l_tx;
		logic signed [31:0] l_ty;
		logic signed [31:0] l_tz;
		logic signed [31:0] l_rx;
		logic signed [31:0] l_ry;
		logic signed [31:0] l_rz;
		logic signed [31:0] focus_row_z;
		logic signed [31:0] focus_cost;
		logic               focus_valid;
		logic               frame_end;
	} lim_out_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  feat;
		logic        dnz;
		logic [30:0] z;
	} lim_cfg_t;

	// Front end results handed to the second multiply section
	typedef struct packed {
		lim_in_t            pix;
		logic signed [31:0] m_ixx;
		logic signed [31:0] m_iyx;
		logic signed [31:0] one_xx;
		logic signed [31:0] one_yy;
		logic signed [31:0] rz;
		logic signed [31:0] negsum;
		logic signed [31:0] dsum;
		logic signed [31:0] par_rx;
		logic signed [31:0] par_ry;
	} lim_s4_t;

	// One divider lane: sign, partial remainder, dividend/quotient shifter
	typedef struct packed {
		logic              neg;
		logic [DIV_RW-1:0] rem;
		logic [DIV_NW-1:0] num;
	} lim_dlane_t;

	typedef lim_dlane_t [NUM_LANE-1:0] lim_lanes_t;

	// Row parts that ride alongside the divider
	typedef struct packed {
		logic               par;
		logic signed [31:0] tx_par;
		logic signed [31:0] ty_par;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] frow;
		logic signed [31:0] fcost;
		logic               fvalid;
		logic               last;
	} lim_aux_t;

	function automatic logic signed [31:0] q_fit33(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? Q_MIN : Q_MAX;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		return q_fit33(s);
	endfunction

	function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} - {b[31], b};
		return q_fit33(s);
	endfunction

	function automatic logic signed [31:0] q_neg(input logic signed [31:0] a);
		return (a == Q_MIN) ? Q_MAX : -a;
	endfunction

	// Raw product to Q16.16: arithmetic shift (floor), then saturate
	function automatic logic signed [31:0] q_mulsat(input logic signed [63:0] p);
		logic [47:0] sh;
		sh = p[63:FRAC];
		if ((&sh[47:31]) || !(|sh[47:31])) begin
			return sh[31:0];
		end
		return sh[47] ? Q_MIN : Q_MAX;
	endfunction

endpackage

>>> src/luminance_interaction_matrix_row_core.sv
// Channel   Handshake                    Payload     Moves
// pix       pix_valid / pix_ready        lim_in_t    one pixel in
// row       row_valid / row_ready        lim_out_t   one interaction row out
// cfg       cfg_we                       cfg_wdata   register write at cfg_index
//
// One pixel per cycle sustained while row_ready stays high; row_valid rises once the pixel has passed every stage.
// The 48-bit restoring divider forms the 1/depth terms: 4 quotient
// bits per stage over 12 stages, after 7 front and middle stages and before an output stage.
// Reset clears the stage valid bits and sets the configuration registers to their defaults.
// A full stage holds only when the one after it holds; empty stages fill under a stall.
module luminance_interaction_matrix_row_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  lim_pkg::lim_in_t  pix,
	output logic              row_valid,
	input  logic              row_ready,
	output lim_pkg::lim_out_t row,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [30:0]       cfg_wdata
);
	import lim_pkg::*;

	logic [1:0]  mode_q, feat_q;
	logic        dnz_q;
	logic [30:0] z_q;
	lim_cfg_t    cfg;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] stg_en;

	lim_s4_t    s4;
	lim_aux_t   aux_mid, aux_div;
	lim_lanes_t lanes_mid, lanes_div;

	logic signed [31:0] quot [NUM_LANE];
	lim_out_t row_n;
	lim_out_t row_s20;

	// Quotient magnitude back to a signed, saturated value
	function automatic logic signed [31:0] div_fin(input lim_dlane_t l);
		if (l.neg) begin
			return (|l.num[DIV_NW-1:31]) ? Q_MIN : -l.num[31:0];
		end
		return (|l.num[DIV_NW-1:31]) ? Q_MAX : l.num[31:0];
	endfunction

	// Configuration registers; zero depth is kept as one LSB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PERSP;
			feat_q <= FEAT_NONE;
			dnz_q  <= 1'b0;
			z_q    <= DEPTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROJ:  mode_q <= cfg_wdata[1:0];
				CFG_FEAT:  feat_q <= cfg_wdata[1:0];
				CFG_DNZ:   dnz_q  <= cfg_wdata[0];
				CFG_DEPTH: z_q    <= (cfg_wdata == '0) ? 31'd1 : cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = '{mode: mode_q, feat: feat_q, dnz: dnz_q, z: z_q};

	// Stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		stg_en[NUM_STG-1] = !vld_q[NUM_STG-1] || row_ready;
		for (int k = NUM_STG - 2; k >= 0; k--) begin
			stg_en[k] = !vld_q[k] || stg_en[k+1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stg_en[0]) begin
				vld_q[0] <= pix_valid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (stg_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign pix_ready = stg_en[0];
	assign row_valid = vld_q[NUM_STG-1];

	lim_front u_front (
		.clk (clk),
		.en  (stg_en[FRONT_STG-1:0]),
		.cfg (cfg),
		.pix (pix),
		.s4  (s4)
	);

	lim_mid u_mid (
		.clk   (clk),
		.en    (stg_en[FRONT_STG+MID_STG-1:FRONT_STG]),
		.cfg   (cfg),
		.s4    (s4),
		.aux   (aux_mid),
		.lanes (lanes_mid)
	);

	lim_div u_div (
		.clk     (clk),
		.en      (stg_en[NUM_STG-2:FRONT_STG+MID_STG]),
		.z       (z_q),
		.lanes_i (lanes_mid),
		.aux_i   (aux_mid),
		.lanes_o (lanes_div),
		.aux_o   (aux_div)
	);

	// Final selection by projection mode
	always_comb begin
		for (int l = 0; l < NUM_LANE; l++) begin
			quot[l] = div_fin(lanes_div[l]);
		end
		row_n.l_tx        = aux_div.par ? aux_div.tx_par : quot[LANE_TX];
		row_n.l_ty        = aux_div.par ? aux_div.ty_par : quot[LANE_TY];
		row_n.l_tz        = aux_div.par ? '0 : quot[LANE_TZ];
		row_n.l_rx        = aux_div.rx;
		row_n.l_ry        = aux_div.ry;
		row_n.l_rz        = aux_div.rz;
		row_n.focus_row_z = aux_div.frow;
		row_n.focus_cost  = aux_div.fcost;
		row_n.focus_valid = aux_div.fvalid;
		row_n.frame_end   = aux_div.last;
	end

	// s20: output register
	always_ff @(posedge clk) begin
		if (stg_en[NUM_STG-1]) begin
			row_s20 <= row_n;
		end
	end

	assign row = row_s20;

endmodule

>>> src/lim_front.sv
module lim_front (
	input  logic              clk,
	input  logic [3:0]        en,
	input  lim_pkg::lim_cfg_t cfg,
	input  lim_pkg::lim_in_t  pix,
	output lim_pkg::lim_s4_t  s4
);
	import lim_pkg::*;

	logic signed [31:0] zs;

	lim_in_t in_s1, in_s2, in_s3;
	logic signed [63:0] p_iyx_s2, p_ixy_s2, p_ixx_s2, p_iyy_s2, p_yy_s2;
	logic signed [63:0] p_xx_s2, p_iyz_s2, p_ixz_s2, p_ixs_s2, p_iys_s2;
	logic signed [31:0] m_iyx_s3, m_ixy_s3, m_ixx_s3, m_iyy_s3, m_yy_s3;
	logic signed [31:0] m_xx_s3, m_iyz_s3, m_ixz_s3, m_ixs_s3, m_iys_s3;
	lim_s4_t res_s4;

	assign zs = $signed({1'b0, cfg.z});

	// s1: input register
	always_ff @(posedge clk) begin
		if (en[0]) begin
			in_s1 <= pix;
		end
	end

	// s2: first round of products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			in_s2    <= in_s1;
			p_iyx_s2 <= in_s1.grad_y * in_s1.coord_x;
			p_ixy_s2 <= in_s1.grad_x * in_s1.coord_y;
			p_ixx_s2 <= in_s1.grad_x * in_s1.coord_x;
			p_iyy_s2 <= in_s1.grad_y * in_s1.coord_y;
			p_yy_s2  <= in_s1.coord_y * in_s1.coord_y;
			p_xx_s2  <= in_s1.coord_x * in_s1.coord_x;
			p_iyz_s2 <= in_s1.grad_y * zs;
			p_ixz_s2 <= in_s1.grad_x * zs;
			p_ixs_s2 <= in_s1.grad_x * in_s1.smooth_grad_x;
			p_iys_s2 <= in_s1.grad_y * in_s1.smooth_grad_y;
		end
	end

	// s3: scale and saturate
	always_ff @(posedge clk) begin
		if (en[2]) begin
			in_s3    <= in_s2;
			m_iyx_s3 <= q_mulsat(p_iyx_s2);
			m_ixy_s3 <= q_mulsat(p_ixy_s2);
			m_ixx_s3 <= q_mulsat(p_ixx_s2);
			m_iyy_s3 <= q_mulsat(p_iyy_s2);
			m_yy_s3  <= q_mulsat(p_yy_s2);
			m_xx_s3  <= q_mulsat(p_xx_s2);
			m_iyz_s3 <= q_mulsat(p_iyz_s2);
			m_ixz_s3 <= q_mulsat(p_ixz_s2);
			m_ixs_s3 <= q_mulsat(p_ixs_s2);
			m_iys_s3 <= q_mulsat(p_iys_s2);
		end
	end

	// s4: sums and negations
	always_ff @(posedge clk) begin
		if (en[3]) begin
			res_s4.pix    <= in_s3;
			res_s4.m_ixx  <= m_ixx_s3;
			res_s4.m_iyx  <= m_iyx_s3;
			res_s4.one_xx <= q_add(Q_ONE, m_xx_s3);
			res_s4.one_yy <= q_add(Q_ONE, m_yy_s3);
			res_s4.rz     <= q_sub(m_iyx_s3, m_ixy_s3);
			res_s4.negsum <= q_neg(q_add(m_ixx_s3, m_iyy_s3));
			res_s4.dsum   <= q_add(m_ixs_s3, m_iys_s3);
			res_s4.par_rx <= q_neg(m_iyz_s3);
			res_s4.par_ry <= m_ixz_s3;
		end
	end

	assign s4 = res_s4;

endmodule

>>> src/lim_mid.sv
module lim_mid (
	input  logic                clk,
	input  logic [2:0]          en,
	input  lim_pkg::lim_cfg_t   cfg,
	input  lim_pkg::lim_s4_t    s4,
	output lim_pkg::lim_aux_t   aux,
	output lim_pkg::lim_lanes_t lanes
);
	import lim_pkg::*;

	logic signed [31:0] d_n, frow_n, fcost_n;
	logic               fvalid_n;
	lim_aux_t           aux_n;
	lim_lanes_t         lanes_n;
	logic signed [31:0] rx_n, ry_n;
	lim_aux_t           aux_rot;

	logic signed [63:0] p_a_s5, p_b_s5, p_c_s5, p_d_s5;
	lim_aux_t           aux_s5, aux_s6, aux_s7;
	lim_lanes_t         lanes_s5, lanes_s6, lanes_s7;
	logic signed [31:0] q_a_s6, q_b_s6, q_c_s6, q_d_s6;

	function automatic lim_dlane_t lane_load(input logic signed [31:0] a);
		lim_dlane_t r;
		logic [31:0] mag;
		mag   = a[31] ? (~a + 32'd1) : a;
		r.neg = a[31];
		r.rem = '0;
		r.num = {mag, {FRAC{1'b0}}};
		return r;
	endfunction

	// Focus terms and divider setup
	always_comb begin
		d_n      = (s4.pix.is_noise && cfg.dnz) ? '0 : s4.dsum;
		fvalid_n = (cfg.mode == MODE_PARFOC) && (cfg.feat != FEAT_NONE);
		frow_n   = '0;
		fcost_n  = '0;
		if (fvalid_n) begin
			if (cfg.feat == FEAT_VAR) begin
				frow_n  = s4.pix.variance_deriv;
				fcost_n = q_add(s4.pix.variance_deriv, s4.pix.variance_deriv);
			end else begin
				frow_n  = q_add(d_n, d_n);
				fcost_n = frow_n;
			end
		end
		aux_n.par    = (cfg.mode == MODE_PAR) || (cfg.mode == MODE_PARFOC);
		aux_n.tx_par = s4.pix.grad_x;
		aux_n.ty_par = s4.pix.grad_y;
		aux_n.rx     = s4.par_rx;
		aux_n.ry     = s4.par_ry;
		aux_n.rz     = s4.rz;
		aux_n.frow   = frow_n;
		aux_n.fcost  = fcost_n;
		aux_n.fvalid = fvalid_n;
		aux_n.last   = s4.pix.last_pixel;
		lanes_n[LANE_TX] = lane_load(s4.pix.grad_x);
		lanes_n[LANE_TY] = lane_load(s4.pix.grad_y);
		lanes_n[LANE_TZ] = lane_load(s4.negsum);
	end

	// s5: second round of products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_a_s5   <= s4.m_ixx * s4.pix.coord_y;
			p_b_s5   <= s4.one_yy * s4.pix.grad_y;
			p_c_s5   <= s4.one_xx * s4.pix.grad_x;
			p_d_s5   <= s4.m_iyx * s4.pix.coord_y;
			aux_s5   <= aux_n;
			lanes_s5 <= lanes_n;
		end
	end

	// s6: scale and saturate
	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_a_s6   <= q_mulsat(p_a_s5);
			q_b_s6   <= q_mulsat(p_b_s5);
			q_c_s6   <= q_mulsat(p_c_s5);
			q_d_s6   <= q_mulsat(p_d_s5);
			aux_s6   <= aux_s5;
			lanes_s6 <= lanes_s5;
		end
	end

	// Rotation entries: perspective form replaces the parallel one
	always_comb begin
		rx_n = aux_s6.par ? aux_s6.rx : q_sub(q_neg(q_a_s6), q_b_s6);
		ry_n = aux_s6.par ? aux_s6.ry : q_add(q_c_s6, q_d_s6);
		aux_rot    = aux_s6;
		aux_rot.rx = rx_n;
		aux_rot.ry = ry_n;
	end

	// s7
	always_ff @(posedge clk) begin
		if (en[2]) begin
			aux_s7   <= aux_rot;
			lanes_s7 <= lanes_s6;
		end
	end

	assign aux   = aux_s7;
	assign lanes = lanes_s7;

endmodule

>>> src/lim_div.sv
module lim_div (
	input  logic                         clk,
	input  logic [lim_pkg::DIV_STG-1:0]  en,
	input  logic [lim_pkg::DIV_RW-1:0]   z,
	input  lim_pkg::lim_lanes_t          lanes_i,
	input  lim_pkg::lim_aux_t            aux_i,
	output lim_pkg::lim_lanes_t          lanes_o,
	output lim_pkg::lim_aux_t            aux_o
);
	import lim_pkg::*;

	lim_lanes_t lanes_s [DIV_STG];
	lim_aux_t   aux_s   [DIV_STG];

	// Restoring division, DIV_BPS quotient bits per call
	function automatic lim_dlane_t div_step(input lim_dlane_t a,
			input logic [DIV_RW-1:0] d);
		lim_dlane_t r;
		logic [DIV_RW:0] t;
		r = a;
		for (int i = 0; i < DIV_BPS; i++) begin
			t = {r.rem, r.num[DIV_NW-1]};
			if (t >= {1'b0, d}) begin
				r.rem = DIV_RW'(t - {1'b0, d});
				r.num = {r.num[DIV_NW-2:0], 1'b1};
			end else begin
				r.rem = t[DIV_RW-1:0];
				r.num = {r.num[DIV_NW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					for (int l = 0; l < NUM_LANE; l++) begin
						lanes_s[k][l] <= div_step(lanes_i[l], z);
					end
					aux_s[k] <= aux_i;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k]) begin
					for (int l = 0; l < NUM_LANE; l++) begin
						lanes_s[k][l] <= div_step(lanes_s[k-1][l], z);
					end
					aux_s[k] <= aux_s[k-1];
				end
			end
		end
	end

	assign lanes_o = lanes_s[DIV_STG-1];
	assign aux_o   = aux_s[DIV_STG-1];

endmodule
